// ----- hw/rtl/psqm_pkg.sv -----
// shared types and constants for the per-session packet queue manager
package psqm_pkg;

  localparam int unsigned CntW = 32;
  localparam int unsigned BufW = 11;
  localparam int unsigned ActW = 7;
  localparam int unsigned LimW = 5;

  localparam logic [2:0] OpEnq   = 3'd0;
  localparam logic [2:0] OpDeq   = 3'd1;
  localparam logic [2:0] OpClr   = 3'd2;
  localparam logic [2:0] OpRdSes = 3'd3;
  localparam logic [2:0] OpRdTot = 3'd4;

  localparam logic [1:0] DropNone   = 2'd0;
  localparam logic [1:0] DropOldest = 2'd1;
  localparam logic [1:0] DropNewest = 2'd2;

  // per-session counter record
  typedef struct packed {
    logic [CntW-1:0] enq;
    logic [CntW-1:0] deq;
    logic [CntW-1:0] evi;
    logic [CntW-1:0] rej;
  } cnt_rec_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [CntW-1:0] sat_sub(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    sat_sub = (a >= b) ? a - b : '0;
  endfunction

endpackage

// ----- hw/rtl/psqm_pkt_ram.sv -----
// packet descriptor store, one write and one registered read port
module psqm_pkt_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- hw/rtl/per_session_packet_queue_manager.sv -----
// top level: per-session queues with counters held in session memory
//
// One operation is accepted when start is high and busy is low; busy
// then stays high for one cycle and the result appears with done_o in the
// cycle after. The session memory is read on accept and written back while
// busy is high. The receiver cannot stall: each result is valid only in
// the cycle done_o is high. Session state (fill, head, counters) lives in
// a memory of NumSessions entries with a valid bit per session cleared at
// reset; the packet store has no reset.
module per_session_packet_queue_manager
  import psqm_pkg::*;
#(
  parameter int unsigned NumSessions = 64,
  parameter int unsigned QueueDepth  = 16,
  parameter int unsigned PacketWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             operation_i,
  input  logic [5:0]             session_i,
  input  logic [31:0]            packet_in_i,
  input  logic                   drop_oldest_i,
  input  logic                   cfg_we_i,
  input  logic [LimW-1:0]        cfg_data_i,
  output logic                   done_o,
  output logic                   accepted_o,
  output logic [1:0]             drop_reason_o,
  output logic                   packet_valid_o,
  output logic [31:0]            packet_out_o,
  output logic [BufW-1:0]        buffered_count_o,
  output logic [CntW-1:0]        enqueued_count_o,
  output logic [CntW-1:0]        dequeued_count_o,
  output logic [CntW-1:0]        evicted_count_o,
  output logic [CntW-1:0]        rejected_count_o,
  output logic [ActW-1:0]        active_sessions_o
);
  localparam int unsigned SesW  = (NumSessions > 1) ? $clog2(NumSessions) : 1;
  localparam int unsigned PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW = SesW + PtrW;
  localparam int unsigned PktW  = (PacketWidth < 32) ? PacketWidth : 32;

  typedef struct packed {
    logic [PtrW-1:0]  head;
    logic [FillW-1:0] fill;
    cnt_rec_t         cnt;
  } ses_rec_t;

  // control
  logic              busy_q;
  logic              done_q;
  logic [LimW-1:0]   limit_q;
  logic [2:0]        op_q;
  logic [SesW-1:0]   ses_q;
  logic              inrange_q;
  logic [PktW-1:0]   pkt_q;
  logic              oldest_q;
  logic [NumSessions-1:0] exists_q;
  logic [CntW-1:0]   tot_enq_q, tot_deq_q, tot_evi_q, tot_rej_q;
  logic [BufW-1:0]   tot_buf_q;
  logic [ActW-1:0]   live_q;

  // session memory
  ses_rec_t          ses_mem [NumSessions];
  ses_rec_t          rd_raw_q;
  ses_rec_t          cur;
  ses_rec_t          nxt;
  logic              ses_we;

  logic              take;
  logic [SesW-1:0]   ses_in;
  logic              inrange_in;
  logic              exists;

  assign busy   = busy_q;
  assign take   = start && !busy_q;
  assign ses_in = SesW'(session_i);
  assign inrange_in = ({26'd0, session_i} < 32'(NumSessions));
  assign exists = exists_q[ses_q];
  assign cur    = exists ? rd_raw_q : '0;

  // session memory read on accept, write-back while busy
  always_ff @(posedge clk_i) begin
    if (take) rd_raw_q <= ses_mem[ses_in];
    if (ses_we) ses_mem[ses_q] <= nxt;
  end

  // effective limit
  logic [FillW:0] lim;
  always_comb begin
    if (limit_q == '0) lim = (FillW+1)'(1);
    else if (32'(limit_q) > QueueDepth) lim = (FillW+1)'(QueueDepth);
    else lim = (FillW+1)'(limit_q);
  end

  // operation decode
  logic            full;
  logic            pk_we;
  logic [PtrW-1:0] pk_slot;
  logic [PtrW-1:0] head_adv;
  logic            deq_ok;
  logic [PtrW-1:0] wslot;
  logic [PtrW:0]   slot_sum;

  assign full     = ({1'b0, cur.fill} >= lim);
  assign deq_ok   = exists && (cur.fill != '0);
  assign head_adv = (32'(cur.head) == QueueDepth - 1) ? '0 : cur.head + 1'b1;

  always_comb begin
    nxt     = cur;
    ses_we  = 1'b0;
    pk_we   = 1'b0;
    wslot   = '0;
    slot_sum = '0;
    if (busy_q && inrange_q) begin
      unique case (op_q)
        OpEnq: begin
          ses_we = 1'b1;
          if (full && !oldest_q) begin
            nxt.cnt.rej = sat_inc(cur.cnt.rej);
          end else begin
            if (full) begin
              nxt.head    = head_adv;
              nxt.cnt.evi = sat_inc(cur.cnt.evi);
              slot_sum = {1'b0, head_adv} + (PtrW+1)'(cur.fill - 1'b1);
            end else begin
              nxt.fill = cur.fill + 1'b1;
              slot_sum = {1'b0, cur.head} + (PtrW+1)'(cur.fill);
            end
            nxt.cnt.enq = sat_inc(cur.cnt.enq);
            pk_we = 1'b1;
            wslot = (32'(slot_sum) >= QueueDepth)
                  ? PtrW'(32'(slot_sum) - QueueDepth) : PtrW'(slot_sum);
          end
        end
        OpDeq: begin
          if (deq_ok) begin
            ses_we = 1'b1;
            nxt.head = head_adv;
            nxt.fill = cur.fill - 1'b1;
            nxt.cnt.deq = sat_inc(cur.cnt.deq);
          end
        end
        OpClr: begin
          if (exists) begin
            ses_we = 1'b1;
            nxt    = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // the head is known only after the session read, so the packet read is issued
  // while busy with the head from session memory and the data is registered out
  assign pk_slot = cur.head;
  logic [PktW-1:0] pk_rd;
  psqm_pkt_ram #(
    .Depth (NumSessions * QueueDepth),
    .Width (PktW),
    .AddrW (AddrW)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (pk_we),
    .waddr_i ({ses_q, wslot}),
    .wdata_i (pkt_q),
    .raddr_i ({ses_q, pk_slot}),
    .rdata_o (pk_rd)
  );

  // control, totals and result registers
  logic            res_acc_q, res_pv_q, deq_pend_q;
  logic [1:0]      res_dr_q;
  logic [BufW-1:0] res_buf_q;
  logic [CntW-1:0] res_enq_q, res_deq_q, res_evi_q, res_rej_q;
  logic [ActW-1:0] res_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      deq_pend_q <= 1'b0;
      limit_q <= LimW'(16);
      exists_q <= '0;
      tot_enq_q <= '0; tot_deq_q <= '0; tot_evi_q <= '0; tot_rej_q <= '0;
      tot_buf_q <= '0;
      live_q <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      busy_q <= take;
      done_q <= busy_q;
      deq_pend_q <= 1'b0;
      if (busy_q && inrange_q) begin
        unique case (op_q)
          OpEnq: begin
            if (!exists) begin
              exists_q[ses_q] <= 1'b1;
              live_q <= live_q + 1'b1;
            end
            if (full && !oldest_q) begin
              tot_rej_q <= sat_inc(tot_rej_q);
            end else begin
              tot_enq_q <= sat_inc(tot_enq_q);
              if (full) tot_evi_q <= sat_inc(tot_evi_q);
              else tot_buf_q <= tot_buf_q + 1'b1;
            end
          end
          OpDeq: begin
            if (deq_ok) begin
              tot_buf_q <= tot_buf_q - 1'b1;
              tot_deq_q <= sat_inc(tot_deq_q);
              deq_pend_q <= 1'b1;
            end
          end
          OpClr: begin
            if (exists) begin
              exists_q[ses_q] <= 1'b0;
              live_q <= live_q - 1'b1;
              tot_enq_q <= sat_sub(tot_enq_q, cur.cnt.enq);
              tot_deq_q <= sat_sub(tot_deq_q, cur.cnt.deq);
              tot_evi_q <= sat_sub(tot_evi_q, cur.cnt.evi);
              tot_rej_q <= sat_sub(tot_rej_q, cur.cnt.rej);
              tot_buf_q <= ({1'b0, tot_buf_q} >= (BufW+1)'(cur.fill))
                         ? tot_buf_q - BufW'(cur.fill) : '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // operand capture and result formation
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= operation_i;
      ses_q     <= ses_in;
      inrange_q <= inrange_in;
      pkt_q     <= PktW'(packet_in_i);
      oldest_q  <= drop_oldest_i;
    end
    if (busy_q) begin
      res_acc_q <= 1'b0; res_dr_q <= DropNone; res_pv_q <= 1'b0;
      res_buf_q <= '0; res_enq_q <= '0; res_deq_q <= '0;
      res_evi_q <= '0; res_rej_q <= '0; res_act_q <= '0;
      if (inrange_q) begin
        case (op_q)
          OpEnq: begin
            if (full && !oldest_q) res_dr_q <= DropNewest;
            else begin
              res_acc_q <= 1'b1;
              if (full) res_dr_q <= DropOldest;
            end
          end
          OpDeq: res_pv_q <= deq_ok;
          OpRdSes: begin
            res_buf_q <= BufW'(cur.fill);
            res_enq_q <= cur.cnt.enq; res_deq_q <= cur.cnt.deq;
            res_evi_q <= cur.cnt.evi; res_rej_q <= cur.cnt.rej;
          end
          OpRdTot: begin
            res_buf_q <= tot_buf_q;
            res_enq_q <= tot_enq_q; res_deq_q <= tot_deq_q;
            res_evi_q <= tot_evi_q; res_rej_q <= tot_rej_q;
            res_act_q <= live_q;
          end
          default: ;
        endcase
      end
    end
  end

  assign done_o            = done_q;
  assign accepted_o        = res_acc_q;
  assign drop_reason_o     = res_dr_q;
  assign packet_valid_o    = res_pv_q;
  assign packet_out_o      = deq_pend_q ? 32'(pk_rd) : '0;
  assign buffered_count_o  = res_buf_q;
  assign enqueued_count_o  = res_enq_q;
  assign dequeued_count_o  = res_deq_q;
  assign evicted_count_o   = res_evi_q;
  assign rejected_count_o  = res_rej_q;
  assign active_sessions_o = res_act_q;
endmodule
